// File: rtl/core/crast_pkg.sv
`timescale 1ns / 1ps

package crast_pkg;

	// Command codes of an input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Status of the step queue between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} crast_qstat_t;

endpackage

// File: rtl/core/crast_queue.sv
`timescale 1ns / 1ps

module crast_queue #(
	parameter int DATA_WIDTH = 8,
	parameter int DEPTH      = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [DATA_WIDTH-1:0]   wr_data,
	input  logic                    rd_en,
	output logic [DATA_WIDTH-1:0]   rd_data,
	output crast_pkg::crast_qstat_t stat
);
	import crast_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// File: rtl/core/crast_front.sv
`timescale 1ns / 1ps

module crast_front #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 11,
	parameter int REC_WIDTH    = 1 + 3 * 12 + 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    command,
	input  logic [COORD_WIDTH-1:0]  center_x,
	input  logic [COORD_WIDTH-1:0]  center_y,
	input  logic [RADIUS_WIDTH-1:0] radius,
	output logic                    full,
	input  crast_pkg::crast_qstat_t q_stat,
	output logic                    q_wr,
	output logic [REC_WIDTH-1:0]    q_data
);
	import crast_pkg::*;

	localparam int OY  = RADIUS_WIDTH + 2;
	localparam int DEC = RADIUS_WIDTH + 5;
	localparam int EW  = ((DEC > COORD_WIDTH + 2) ? DEC : COORD_WIDTH + 2) + 2;
	localparam logic signed [EW-1:0] ONE_E = 1;

	logic [COORD_WIDTH-1:0] centre_col_q;
	logic [COORD_WIDTH-1:0] centre_row_q;
	logic [COORD_WIDTH-1:0] offset_x_q;
	logic signed [OY-1:0]   offset_y_q;
	logic signed [DEC-1:0]  decision_q;

	logic                   accept;
	logic                   active;
	logic signed [EW-1:0]   x_e, y_e, d_e, x1_e, y1_e;
	logic signed [EW-1:0]   d_h, d_v, d_d, y_new;
	logic                   horiz, vert, done;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;
	assign active = !offset_y_q[OY-1];

	// Widen state for exact compares
	assign x_e  = EW'({1'b0, offset_x_q});
	assign y_e  = EW'(offset_y_q);
	assign d_e  = EW'(decision_q);
	assign x1_e = x_e + ONE_E;
	assign y1_e = y_e - ONE_E;

	// Pick the move: horizontal, vertical or diagonal
	assign horiz = (d_e < 0) && ((d_e + y_e) <= 0);
	assign vert  = !horiz && (d_e > 0) && (d_e > x_e);
	assign d_h   = d_e + (x1_e <<< 1) + ONE_E;
	assign d_v   = d_e + ONE_E - (y1_e <<< 1);
	assign d_d   = d_e + ((x1_e - y_e) <<< 1);
	assign y_new = horiz ? y_e : y1_e;
	assign done  = y_new[EW-1];

	// Hand the current offsets to the back end
	assign q_wr   = accept && (command == CMD_STEP) && active;
	assign q_data = {done, centre_col_q, centre_row_q, offset_x_q, offset_y_q};

	// Load on start, update on step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_col_q <= '0;
			centre_row_q <= '0;
			offset_x_q   <= '0;
			offset_y_q   <= '1;
			decision_q   <= '0;
		end else if (accept) begin
			if (command == CMD_START) begin
				centre_col_q <= center_x;
				centre_row_q <= center_y;
				offset_x_q   <= '0;
				offset_y_q   <= OY'(radius);
				decision_q   <= DEC'(2) - DEC'({radius, 1'b0});
			end else if (active) begin
				if (horiz) begin
					offset_x_q <= x1_e[COORD_WIDTH-1:0];
					decision_q <= d_h[DEC-1:0];
				end else if (vert) begin
					offset_y_q <= y1_e[OY-1:0];
					decision_q <= d_v[DEC-1:0];
				end else begin
					offset_x_q <= x1_e[COORD_WIDTH-1:0];
					offset_y_q <= y1_e[OY-1:0];
					decision_q <= d_d[DEC-1:0];
				end
			end
		end
	end

endmodule

// File: rtl/core/crast_back.sv
`timescale 1ns / 1ps

module crast_back #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 11,
	parameter int REC_WIDTH    = 1 + 3 * 12 + 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  crast_pkg::crast_qstat_t        q_stat,
	input  logic [REC_WIDTH-1:0]           q_data,
	output logic                           q_rd,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [COORD_WIDTH+1:0]  pixel_x,
	output logic signed [COORD_WIDTH+1:0]  pixel_y,
	output logic                           last,
	output logic                           done_res
);
	import crast_pkg::*;

	localparam int OY = RADIUS_WIDTH + 2;
	localparam int PW = COORD_WIDTH + 2;
	localparam int SW = (OY > PW) ? OY : PW;
	localparam logic [1:0] LAST_QUAD = 2'd3;

	logic [REC_WIDTH-1:0]   rec_q;
	logic                   rec_valid_q;
	logic [1:0]             quad_q;
	logic                   out_valid_q;
	logic signed [PW-1:0]   pixel_x_q, pixel_y_q;
	logic                   last_q, done_q;

	logic                   rec_done;
	logic [COORD_WIDTH-1:0] rec_cx, rec_cy, rec_ox;
	logic signed [OY-1:0]   rec_oy;
	logic signed [SW-1:0]   oy_ext;
	logic [PW-1:0]          cx_p, cy_p, ox_p, oy_p;
	logic                   out_free, emit;

	assign {rec_done, rec_cx, rec_cy, rec_ox, rec_oy} = rec_q;

	// Extend the record fields to the pixel width for the quadrant mirror
	assign oy_ext = SW'(rec_oy);
	assign oy_p   = oy_ext[PW-1:0];
	assign cx_p   = PW'(rec_cx);
	assign cy_p   = PW'(rec_cy);
	assign ox_p   = PW'(rec_ox);

	assign out_free = !out_valid_q || pop;
	assign emit     = rec_valid_q && out_free;
	assign q_rd     = !q_stat.empty && (!rec_valid_q || (emit && quad_q == LAST_QUAD));

	// Take records and step through the four quadrants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			quad_q      <= '0;
		end else begin
			if (q_rd) begin
				rec_valid_q <= 1'b1;
				quad_q      <= '0;
			end else if (emit) begin
				quad_q <= quad_q + 2'd1;
				if (quad_q == LAST_QUAD) begin
					rec_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			rec_q <= q_data;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rec_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q <= quad_q[0] ? (cx_p - ox_p) : (cx_p + ox_p);
			pixel_y_q <= quad_q[1] ? (cy_p - oy_p) : (cy_p + oy_p);
			last_q    <= (quad_q == LAST_QUAD);
			done_q    <= rec_done;
		end
	end

	assign empty    = !out_valid_q;
	assign pixel_x  = pixel_x_q;
	assign pixel_y  = pixel_y_q;
	assign last     = last_q;
	assign done_res = done_q;

endmodule

// File: rtl/core/circle_rasterizer.sv
// A step's first pixel goes through the step queue, the record register and the output
// register to the result ports. Throughput: one pixel per cycle while pop takes each one,
// four pixels per step from the back end's quadrant sequencer; a start item gives no pixels.
// The front end takes one item per cycle until its two-entry step queue fills.
// Reset (arst_n low, asynchronous) empties the queue and output and leaves the block idle.
`timescale 1ns / 1ps

module circle_rasterizer #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          command,
	input  logic [COORD_WIDTH-1:0]        center_x,
	input  logic [COORD_WIDTH-1:0]        center_y,
	input  logic [RADIUS_WIDTH-1:0]       radius,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH+1:0] pixel_x,
	output logic signed [COORD_WIDTH+1:0] pixel_y,
	output logic                          last,
	output logic                          done_res
);
	import crast_pkg::*;

	localparam int REC_WIDTH = 1 + 3 * COORD_WIDTH + RADIUS_WIDTH + 2;

	crast_qstat_t         q_stat;
	logic                 q_wr, q_rd;
	logic [REC_WIDTH-1:0] q_wdata, q_rdata;

	// Classify items and update the circle state
	crast_front #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RADIUS_WIDTH (RADIUS_WIDTH),
		.REC_WIDTH    (REC_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.full     (full),
		.q_stat   (q_stat),
		.q_wr     (q_wr),
		.q_data   (q_wdata)
	);

	// Buffer steps between front and back
	crast_queue #(
		.DATA_WIDTH (REC_WIDTH),
		.DEPTH      (2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.stat    (q_stat)
	);

	// Emit the four mirrored pixels of each step
	crast_back #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RADIUS_WIDTH (RADIUS_WIDTH),
		.REC_WIDTH    (REC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (q_rdata),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.last     (last),
		.done_res (done_res)
	);

endmodule
